// ===== hw/rtl/kvls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvls_pkg
// Shared types and codes for the linear-search key-value table.
// ----------------------------------------------------------------------------
package kvls_pkg;

  // field widths of one request and one response
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 72;   // op + key + value, padded to bytes

  // request field positions in the slave tdata
  localparam int OP_LSB  = 0;
  localparam int KEY_LSB = OP_LSB + OP_W;
  localparam int VAL_LSB = KEY_LSB + KEY_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_SET    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // response status codes
  localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_HERE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LAST_RD,
    ST_APPLY
  } kvls_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_req;   // capture the request beat, restart the scan
    logic search;     // scan one slot per cycle
    logic last_rd;    // read the last occupied slot
    logic apply;      // update the store, load the response register
  } kvls_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic search_done;
    logic hit;
    logic is_remove;
    logic out_free;
  } kvls_status_t;

endpackage

// ===== hw/rtl/kvls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvls_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module kvls_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/kvls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvls_ctrl
// Sequencer for the key-value table: accept, scan, fetch last entry, apply.
// ----------------------------------------------------------------------------
module kvls_ctrl
  import kvls_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  kvls_status_t sts,
  output kvls_cmd_t    cmd
);

  kvls_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts.search_done) begin
          if (sts.is_remove && sts.hit) state_next = ST_LAST_RD;
          else                          state_next = ST_APPLY;
        end
      end
      ST_LAST_RD: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready     = 1'b1;
        cmd.load_req = s_tvalid;
      end
      ST_SEARCH:  cmd.search  = 1'b1;
      ST_LAST_RD: cmd.last_rd = 1'b1;
      ST_APPLY:   cmd.apply   = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/kvls_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvls_datapath
// Key and value memories, entry count, slot scanner and response register.
// ----------------------------------------------------------------------------
module kvls_datapath
  import kvls_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = $clog2(CAPACITY + 1),
  parameter int OUT_W       = ((STAT_W + VAL_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  input  kvls_cmd_t        cmd,
  output kvls_status_t     sts
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // request registers
  logic [OP_W-1:0]        req_op;
  logic [KEY_W-1:0]       req_key;
  logic [VAL_W-1:0]       req_val;

  // store state
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       rd_ptr;
  logic                   cmp_valid;
  logic [AW-1:0]          cmp_idx;
  logic                   hit_reg;
  logic [AW-1:0]          hit_idx;
  logic [VALUE_WIDTH-1:0] found_val;

  // memory ports
  logic                   re;
  logic [AW-1:0]          raddr;
  logic [KEY_W-1:0]       key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [KEY_W-1:0]       key_wd;
  logic [VALUE_WIDTH-1:0] val_wd;

  // misc
  logic                   hit_now;
  logic                   scan_end;
  logic                   full;
  logic [63:0]            val_in64;
  logic [63:0]            found64;
  logic [CNT_W-1:0]       cnt_last;
  logic [CNT_W-1:0]       cnt_after;
  logic [STAT_W-1:0]      res_stat;
  logic [VAL_W-1:0]       res_val;

  assign val_in64 = {32'd0, req_val};
  assign found64  = 64'(found_val);
  assign cnt_last = cnt - CNT_W'(1);
  assign full     = (cnt >= CNT_W'(CAPACITY));

  // scan compare, one slot per cycle behind the read
  assign hit_now  = cmd.search && cmp_valid && (key_q == req_key);
  assign scan_end = (rd_ptr >= cnt);

  assign sts.search_done = hit_now || scan_end;
  assign sts.hit         = hit_now;
  assign sts.is_remove   = (req_op == OP_REMOVE);
  assign sts.out_free    = !m_tvalid || m_tready;

  // read port: scan address or last occupied slot
  always_comb begin
    re    = 1'b0;
    raddr = rd_ptr[AW-1:0];
    if (cmd.search && !scan_end) begin
      re = 1'b1;
    end else if (cmd.last_rd) begin
      re    = 1'b1;
      raddr = cnt_last[AW-1:0];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op  <= s_tdata[OP_LSB +: OP_W];
      req_key <= s_tdata[KEY_LSB +: KEY_W];
      req_val <= s_tdata[VAL_LSB +: VAL_W];
    end
  end

  // scan pointer and compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      cmp_valid <= 1'b0;
      hit_reg   <= 1'b0;
    end else if (cmd.load_req) begin
      rd_ptr    <= '0;
      cmp_valid <= 1'b0;
      hit_reg   <= 1'b0;
    end else if (cmd.search) begin
      cmp_valid <= re;
      if (re) rd_ptr <= rd_ptr + CNT_W'(1);
      if (hit_now) hit_reg <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) cmp_idx <= raddr;
    if (hit_now) begin
      hit_idx   <= cmp_idx;
      found_val <= val_q;
    end
  end

  // store update and response
  always_comb begin
    we        = 1'b0;
    waddr     = hit_idx;
    key_wd    = req_key;
    val_wd    = val_in64[VALUE_WIDTH-1:0];
    cnt_after = cnt;
    res_stat  = STAT_DONE;
    res_val   = '0;
    unique case (req_op)
      OP_SET: begin
        if (hit_reg) begin
          we = 1'b1;
        end else if (full) begin
          res_stat = STAT_FULL;
        end else begin
          we        = 1'b1;
          waddr     = cnt[AW-1:0];
          cnt_after = cnt + CNT_W'(1);
        end
      end
      OP_GET: begin
        if (hit_reg) res_val  = found64[VAL_W-1:0];
        else         res_stat = STAT_NOT_HERE;
      end
      OP_REMOVE: begin
        if (hit_reg) begin
          we        = 1'b1;
          key_wd    = key_q;
          val_wd    = val_q;
          cnt_after = cnt_last;
        end else begin
          res_stat = STAT_NOT_HERE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.apply) begin
      cnt <= cnt_after;
    end
  end

  // response register, one beat deep
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.apply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      m_tdata <= OUT_W'({cnt_after, res_val, res_stat});
    end
  end

  kvls_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY), .ADDR_W(AW)) u_key_ram (
    .clk   (clk),
    .we    (we && cmd.apply),
    .waddr (waddr),
    .wdata (key_wd),
    .re    (re),
    .raddr (raddr),
    .rdata (key_q)
  );

  kvls_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY), .ADDR_W(AW)) u_val_ram (
    .clk   (clk),
    .we    (we && cmd.apply),
    .waddr (waddr),
    .wdata (val_wd),
    .re    (re),
    .raddr (raddr),
    .rdata (val_q)
  );

endmodule

// ===== hw/rtl/key_value_table_linear_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_linear_search_unit
// Fixed-capacity key-value table with set, get and remove by linear search.
// ----------------------------------------------------------------------------
// One request beat gives one response beat. Entries sit packed in slots 0 to
// count-1 of a key memory and a value memory and are scanned from slot 0 up,
// one slot per cycle through the memories' single read port. A miss scans
// every occupied slot; a successful remove also fetches the last entry, which
// moves into the freed slot. The next request is taken in the cycle after the
// response is loaded. One request is in work at a time; a finished response
// waits in an output register while the next request is accepted, and the
// apply step of that next request waits for as long as the earlier response
// is not taken.
module key_value_table_linear_search_unit
  import kvls_pkg::*;
#(
  parameter  int CAPACITY    = 16,
  parameter  int VALUE_WIDTH = 32,
  localparam int CNT_W       = $clog2(CAPACITY + 1),
  localparam int OUT_W       = ((STAT_W + VAL_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // operation, key, value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status, read_value, entry_count
);

  kvls_cmd_t    cmd;
  kvls_status_t sts;

  kvls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kvls_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W),
    .OUT_W       (OUT_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

  // entry count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[STAT_W+VAL_W +: CNT_W] <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

  // an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

  // the response register is only loaded when it is free
  a_apply_free: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> (!m_tvalid || m_tready))
    else $error("response overwritten");

  // a new response beat follows an apply step
  a_resp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.apply))
    else $error("response without apply");

endmodule

// ===== sim/kv_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kv_table_checker
// Response predictor and comparator for the linear-search key-value table.
// ----------------------------------------------------------------------------
// Watches the request and response streams of the table. Every accepted
// request beat is applied to a private copy of the table, and the response
// that copy gives is queued. Every accepted response beat is compared field
// by field with the oldest queued response. The failure count and the number
// of responses still owed are handed to the testbench top.
module kv_table_checker
  import kvls_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5,
  parameter int OUT_W    = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // operation, key, value
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,   // status, read_value, entry_count
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
    logic [CNT_W-1:0]  entry_count;
  } table_reply_t;

  // private copy of the table contents
  logic [KEY_W-1:0] key_slots   [CAPACITY];
  logic [VAL_W-1:0] value_slots [CAPACITY];
  int               entry_total;

  table_reply_t expected_replies [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    entry_total = 0;
  end

  // lowest occupied slot holding the key, or -1 when it is absent
  function automatic int find_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < entry_total; i++) begin
      if (key_slots[i] == k) return i;
    end
    return -1;
  endfunction

  // apply one request to the table copy and give the response it causes
  function automatic table_reply_t apply_request(logic [OP_W-1:0] op,
                                                 logic [KEY_W-1:0] k,
                                                 logic [VAL_W-1:0] v);
    table_reply_t r;
    int           slot;
    r.status     = STAT_DONE;
    r.read_value = '0;
    slot         = find_key(k);
    case (op)
      OP_SET: begin
        if (slot >= 0) begin
          value_slots[slot] = v;
        end else if (entry_total >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          key_slots[entry_total]   = k;
          value_slots[entry_total] = v;
          entry_total++;
        end
      end
      OP_GET: begin
        if (slot >= 0) r.read_value = value_slots[slot];
        else r.status = STAT_NOT_HERE;
      end
      OP_REMOVE: begin
        // the last entry moves into the freed slot
        if (slot >= 0) begin
          entry_total--;
          key_slots[slot]   = key_slots[entry_total];
          value_slots[slot] = value_slots[entry_total];
        end else begin
          r.status = STAT_NOT_HERE;
        end
      end
      default: ; // the spare code leaves the table alone
    endcase
    r.entry_count = entry_total[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t ns: mismatch in %s, got 0x%0h, want 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // compare responses first, then predict from the request of the same edge
  always @(posedge clk) begin
    table_reply_t seen;
    table_reply_t want;
    if (rst) begin
      entry_total = 0;
      expected_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.status      = m_tdata[0 +: STAT_W];
        seen.read_value  = m_tdata[STAT_W +: VAL_W];
        seen.entry_count = m_tdata[STAT_W + VAL_W +: CNT_W];
        if (expected_replies.size() == 0) begin
          report_mismatch("unrequested response beat", m_tdata, 0);
        end else begin
          want = expected_replies.pop_front();
          if (seen.status != want.status)
            report_mismatch("status", seen.status, want.status);
          if (seen.read_value != want.read_value)
            report_mismatch("read_value", seen.read_value, want.read_value);
          if (seen.entry_count != want.entry_count)
            report_mismatch("entry_count", seen.entry_count, want.entry_count);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_replies.push_back(apply_request(s_tdata[OP_LSB +: OP_W],
                                                 s_tdata[KEY_LSB +: KEY_W],
                                                 s_tdata[VAL_LSB +: VAL_W]));
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule

// ===== sim/key_value_table_linear_search_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_linear_search_unit_tb
// Stimulus and verdict for the linear-search key-value table.
// ----------------------------------------------------------------------------
// A short directed run covers the empty table, the key extremes, updates,
// misses, the spare operation code and removal with a moved entry. Random
// requests follow, mostly on a small pool of keys so that the table fills,
// overflows and drains, with some noise on random keys. Three idling phases
// vary the gaps on both sides; one long receiver hold-off fills the block up
// and the sender pauses now and then until every response is back.
module key_value_table_linear_search_unit_tb;
  import kvls_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OUT_W       = ((STAT_W + VAL_W + CNT_W + 7) / 8) * 8;
  localparam int PAD_W       = IN_W - VAL_LSB - VAL_W;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 450;
  localparam int BLOCK_ITEMS = 40;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 5000;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tready = 1'b0;
  logic             s_tready;
  logic             m_tvalid;
  logic [OUT_W-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  key_value_table_linear_search_unit #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VAL_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  kv_table_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .OUT_W    (OUT_W)
  ) table_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // response side: random back-pressure, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request beat and wait until it is taken
  task automatic offer_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                               logic [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, v, k, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the sender until every owed response has come back
  task automatic wait_for_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly pool keys with a given share of sets, some noise on random keys
  task automatic offer_random(int set_pct);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case ($urandom_range(0, 2))
        0:       op = OP_GET;
        1:       op = OP_REMOVE;
        default: op = OP_SPARE;
      endcase
      k = $urandom;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < set_pct) op = OP_SET;
      else if (pick < set_pct + (100 - set_pct) / 2) op = OP_GET;
      else op = OP_REMOVE;
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    offer_request(op, k, $urandom);
  endtask

  initial begin
    int set_pct;
    // key pool: extremes plus random patterns
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst         <= 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct <= 87;

    // empty table: misses and the spare code
    offer_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    offer_request(OP_REMOVE, 32'h0000_0000, 32'hffff_ffff);
    offer_request(OP_SPARE, 32'hffff_ffff, 32'hffff_ffff);
    // key and value extremes
    offer_request(OP_SET, 32'h8000_0000, 32'h0000_0000);
    offer_request(OP_SET, 32'h7fff_ffff, 32'hffff_ffff);
    offer_request(OP_SET, 32'h0000_0000, 32'h5a5a_5a5a);
    offer_request(OP_SET, 32'hffff_ffff, 32'ha5a5_a5a5);
    offer_request(OP_GET, 32'h8000_0000, 32'hffff_ffff);
    offer_request(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
    // update of an existing key
    offer_request(OP_SET, 32'h7fff_ffff, 32'h0000_0001);
    offer_request(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
    offer_request(OP_SPARE, 32'h0000_0000, 32'h0000_0000);
    offer_request(OP_GET, 32'h1234_5678, 32'h0000_0000);
    // remove from slot 0, last entry moves down
    offer_request(OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
    offer_request(OP_GET, 32'hffff_ffff, 32'h0000_0000);
    offer_request(OP_REMOVE, 32'hffff_ffff, 32'h0000_0000);
    offer_request(OP_REMOVE, 32'h1234_5678, 32'h0000_0000);
    offer_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    offer_request(OP_REMOVE, 32'h7fff_ffff, 32'h0000_0000);
    offer_request(OP_GET, 32'h7fff_ffff, 32'h0000_0000);

    // random phases with different idling on each side
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct <= 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct <= 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          hold_req    <= hold_req + 1;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // first block fills the table past capacity
        if (n % BLOCK_ITEMS == 0)
          set_pct = (phase == 0 && n == 0) ? 95 : 20 + 25 * $urandom_range(0, 3);
        if (n == PHASE_ITEMS / 2) wait_for_replies();
        offer_random(set_pct);
      end
    end
    s_tvalid <= 1'b0;

    wait_for_replies();
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
